[hw/rtl/bu2x_pkg.sv]
package bu2x_pkg;

  // Line store and image limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Fixed field widths
  localparam int PIX_W       = 32;
  localparam int SRC_WIDTH_W = 11;
  localparam int SRC_HEIGHT_W = 13;
  localparam int OUT_ROW_W   = 13;
  localparam int OUT_COL_W   = 11;

  // Register map
  localparam int REG_SRC_WIDTH  = 0;
  localparam int REG_SRC_HEIGHT = 1;
  localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RST  = SRC_WIDTH_W'(1024);
  localparam logic [SRC_HEIGHT_W-1:0] SRC_HEIGHT_RST = SRC_HEIGHT_W'(1);

  // Work queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [QPTR_W:0]  qcount_t;

  // One classified source pixel with its neighborhood
  typedef struct packed {
    pix_t  left;     // pixel to the left in this row
    pix_t  right;    // the new pixel
    pix_t  upleft;   // pixel above left
    pix_t  upright;  // pixel above the new one
    row_t  row;
    col_t  col;
    logic  has_pair; // a block for the column pair ending here
    logic  edge_blk; // pixel ends its row: emit the edge block too
  } entry_t;

endpackage

[hw/rtl/bu2x_ram.sv]
module bu2x_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/bu2x_front.sv]
module bu2x_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bu2x_pkg::pix_t                      in_pixel,
  input  logic [bu2x_pkg::SRC_WIDTH_W-1:0]    src_width,
  input  logic [bu2x_pkg::SRC_HEIGHT_W-1:0]   src_height,
  input  bu2x_pkg::qcount_t                   q_count,
  output logic                                q_push,
  output bu2x_pkg::entry_t                    q_entry
);

  logic                    accept;
  bu2x_pkg::col_t          col_r, col_nxt;
  bu2x_pkg::row_t          row_r, row_nxt;
  bu2x_pkg::pix_t          prev_pixel_r;
  bu2x_pkg::pix_t          above_prev_r;
  logic [bu2x_pkg::COL_W:0] w_eff;
  logic [bu2x_pkg::ROW_W:0] h_eff;
  bu2x_pkg::col_t          col_last;
  bu2x_pkg::row_t          row_last;
  logic                    row_end;
  bu2x_pkg::pix_t          above_cur;

  // Stage after the line store read
  logic                    s1_valid_r;
  bu2x_pkg::pix_t          s1_cur_r;
  bu2x_pkg::pix_t          s1_left_r;
  bu2x_pkg::row_t          s1_row_r;
  bu2x_pkg::col_t          s1_col_r;
  logic                    s1_pair_r;
  logic                    s1_edge_r;

  // Room for the beat in flight too
  assign in_ready = (q_count + bu2x_pkg::qcount_t'(s1_valid_r))
                    < bu2x_pkg::qcount_t'(bu2x_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;

  // Clamp the image size
  always_comb begin
    if (src_width == '0) begin
      w_eff = (bu2x_pkg::COL_W+1)'(1);
    end else if (32'(src_width) > bu2x_pkg::MAX_WIDTH) begin
      w_eff = (bu2x_pkg::COL_W+1)'(bu2x_pkg::MAX_WIDTH);
    end else begin
      w_eff = (bu2x_pkg::COL_W+1)'(src_width);
    end
    if (src_height == '0) begin
      h_eff = (bu2x_pkg::ROW_W+1)'(1);
    end else if (32'(src_height) > bu2x_pkg::MAX_HEIGHT) begin
      h_eff = (bu2x_pkg::ROW_W+1)'(bu2x_pkg::MAX_HEIGHT);
    end else begin
      h_eff = (bu2x_pkg::ROW_W+1)'(src_height);
    end
  end

  assign col_last = bu2x_pkg::col_t'(w_eff - 1'b1);
  assign row_last = bu2x_pkg::row_t'(h_eff - 1'b1);
  assign row_end  = col_r >= col_last;

  // Raster position of the next pixel
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (row_r >= row_last) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      prev_pixel_r <= '0;
      above_prev_r <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= accept;
      if (accept) begin
        prev_pixel_r <= in_pixel;
      end
      if (s1_valid_r) begin
        above_prev_r <= above_cur;
      end
    end
  end

  // Payload of the beat in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur_r  <= in_pixel;
      s1_left_r <= prev_pixel_r;
      s1_row_r  <= row_r;
      s1_col_r  <= col_r;
      s1_pair_r <= col_r != '0;
      s1_edge_r <= row_end;
    end
  end

  // Previous source row: read the pixel above, then overwrite it
  bu2x_ram #(
    .WIDTH (bu2x_pkg::PIX_W),
    .DEPTH (bu2x_pkg::MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata (in_pixel),
    .re    (accept),
    .raddr (col_r),
    .rdata (above_cur)
  );

  // Hand the neighborhood to the queue
  assign q_push = s1_valid_r;
  always_comb begin
    q_entry.left     = s1_left_r;
    q_entry.right    = s1_cur_r;
    q_entry.upleft   = above_prev_r;
    q_entry.upright  = above_cur;
    q_entry.row      = s1_row_r;
    q_entry.col      = s1_col_r;
    q_entry.has_pair = s1_pair_r;
    q_entry.edge_blk = s1_edge_r;
  end

  // Checks
  a_flight_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> q_count < bu2x_pkg::qcount_t'(bu2x_pkg::QUEUE_DEPTH))
    else $error("front: beat in flight with the queue full");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !row_end |=> col_r == $past(col_r) + 1'b1)
    else $error("front: column did not advance");

endmodule

[hw/rtl/bu2x_queue.sv]
module bu2x_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bu2x_pkg::entry_t  push_entry,
  input  logic              pop,
  output logic              head_valid,
  output bu2x_pkg::entry_t  head_entry,
  output bu2x_pkg::qcount_t count
);

  bu2x_pkg::entry_t              slots [bu2x_pkg::QUEUE_DEPTH];
  logic [bu2x_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  bu2x_pkg::qcount_t             count_r;

  assign count      = count_r;
  assign head_valid = count_r != '0;
  assign head_entry = slots[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r < bu2x_pkg::qcount_t'(bu2x_pkg::QUEUE_DEPTH) || pop)
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue: pop while empty");

endmodule

[hw/rtl/bu2x_back.sv]
module bu2x_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  head_valid,
  input  bu2x_pkg::entry_t                      head_entry,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output bu2x_pkg::pix_t                        out_pixel,
  output logic [bu2x_pkg::OUT_ROW_W-1:0]        out_row,
  output logic [bu2x_pkg::OUT_COL_W-1:0]        out_col,
  output logic                                  out_last
);

  // Per channel average, alpha the larger of the two
  function automatic bu2x_pkg::pix_t mix2(input bu2x_pkg::pix_t x, input bu2x_pkg::pix_t y);
    bu2x_pkg::pix_t r;
    logic [8:0]     s;
    r[31:24] = (x[31:24] > y[31:24]) ? x[31:24] : y[31:24];
    for (int k = 0; k < 3; k++) begin
      s = {1'b0, x[k*8 +: 8]} + {1'b0, y[k*8 +: 8]};
      r[k*8 +: 8] = s[8:1];
    end
    return r;
  endfunction

  // Four-way average, alpha taken from the third pixel
  function automatic bu2x_pkg::pix_t mix4(input bu2x_pkg::pix_t a, input bu2x_pkg::pix_t b,
                                          input bu2x_pkg::pix_t c, input bu2x_pkg::pix_t d);
    bu2x_pkg::pix_t r;
    logic [9:0]     s;
    r[31:24] = c[31:24];
    for (int k = 0; k < 3; k++) begin
      s = {2'b00, a[k*8 +: 8]} + {2'b00, b[k*8 +: 8]}
        + {2'b00, c[k*8 +: 8]} + {2'b00, d[k*8 +: 8]};
      r[k*8 +: 8] = s[9:2];
    end
    return r;
  endfunction

  logic [1:0]          phase_r;
  logic                pair_done_r;
  logic                blk_edge;
  logic                has_work;
  logic                out_free;
  logic                emit;
  logic                skip;
  logic                last_beat;
  bu2x_pkg::pix_t      l_pix, r_pix, ul_pix, ur_pix;
  bu2x_pkg::col_t      pair_col;
  bu2x_pkg::pix_t      low_odd, e0, e1, res_pix;

  logic                out_valid_r;
  bu2x_pkg::pix_t      out_pixel_r;
  logic [bu2x_pkg::OUT_ROW_W-1:0] out_row_r;
  logic [bu2x_pkg::OUT_COL_W-1:0] out_col_r;
  logic                out_last_r;

  // Which block of the head item is being sent
  assign blk_edge  = !head_entry.has_pair || pair_done_r;
  assign has_work  = head_entry.has_pair || head_entry.edge_blk;
  assign out_free  = !out_valid_r || out_ready;
  assign emit      = head_valid && has_work && out_free;
  assign skip      = head_valid && !has_work;
  assign last_beat = (phase_r == 2'd3) && (blk_edge || !head_entry.edge_blk);
  assign pop       = skip || (emit && last_beat);

  // Block neighborhood
  always_comb begin
    if (blk_edge) begin
      l_pix    = head_entry.right;
      r_pix    = head_entry.right;
      ul_pix   = head_entry.upright;
      ur_pix   = head_entry.upright;
      pair_col = head_entry.col;
    end else begin
      l_pix    = head_entry.left;
      r_pix    = head_entry.right;
      ul_pix   = head_entry.upleft;
      ur_pix   = head_entry.upright;
      pair_col = head_entry.col - 1'b1;
    end
  end

  // Interpolated pixel of this beat
  always_comb begin
    low_odd = blk_edge ? l_pix : mix2(l_pix, r_pix);
    if (head_entry.row == '0) begin
      e0 = l_pix;
      e1 = low_odd;
    end else begin
      e0 = mix2(ul_pix, l_pix);
      e1 = blk_edge ? e0 : mix4(ul_pix, ur_pix, l_pix, r_pix);
    end
    case (phase_r)
      2'd0:    res_pix = e0;
      2'd1:    res_pix = e1;
      2'd2:    res_pix = l_pix;
      2'd3:    res_pix = low_odd;
      default: res_pix = e0;
    endcase
  end

  // Beat sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      pair_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        phase_r <= phase_r + 1'b1;
        if (phase_r == 2'd3) begin
          pair_done_r <= !last_beat;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel_r <= res_pix;
      out_row_r   <= bu2x_pkg::OUT_ROW_W'({head_entry.row, phase_r[1]});
      out_col_r   <= bu2x_pkg::OUT_COL_W'({pair_col, phase_r[0]});
      out_last_r  <= last_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

  // Checks
  a_pop_on_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !skip |-> phase_r == 2'd3)
    else $error("back: item retired mid-block");

  a_phase_rests: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> phase_r == 2'd0 && !pair_done_r)
    else $error("back: sequencer busy with no item");

endmodule

[hw/rtl/bilinear_upscale_2x_unit.sv]
// A pixel's first result passes the front stage, the work queue and the output register.
// Throughput: one result per cycle while out_ready holds; a pixel gives 0, 4 or 8 results,
//   and a row's empty first pixel, when W > 1, still takes its turn at the queue head.
// A 4-entry work queue lets input beats run ahead of the output by up to four pixels.
// Reset (synchronous, rst_n low): counters and queue empty, src_width 1024, src_height 1;
//   the line store is not cleared and needs no clearing pass.
module bilinear_upscale_2x_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Source pixels
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [31:0]                          in_pixel,
  // Upscaled pixels
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [31:0]                          out_pixel,
  output logic [12:0]                          out_row,
  output logic [10:0]                          out_col,
  output logic                                 out_last,
  // Register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [bu2x_pkg::SRC_WIDTH_W-1:0]  src_width_r;
  logic [bu2x_pkg::SRC_HEIGHT_W-1:0] src_height_r;
  logic                              reg_wr;
  logic                              reg_sel;

  logic                              q_push;
  bu2x_pkg::entry_t                  q_entry;
  logic                              q_pop;
  logic                              q_head_valid;
  bu2x_pkg::entry_t                  q_head;
  bu2x_pkg::qcount_t                 q_count;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= bu2x_pkg::SRC_WIDTH_RST;
      src_height_r <= bu2x_pkg::SRC_HEIGHT_RST;
    end else if (reg_wr) begin
      if (reg_sel == 1'(bu2x_pkg::REG_SRC_WIDTH)) begin
        src_width_r <= pwdata[bu2x_pkg::SRC_WIDTH_W-1:0];
      end else begin
        src_height_r <= pwdata[bu2x_pkg::SRC_HEIGHT_W-1:0];
      end
    end
  end

  always_comb begin
    case (reg_sel)
      1'(bu2x_pkg::REG_SRC_WIDTH):  prdata = 32'(src_width_r);
      1'(bu2x_pkg::REG_SRC_HEIGHT): prdata = 32'(src_height_r);
      default:                      prdata = '0;
    endcase
  end

  // Front: raster counters and line store
  bu2x_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel   (in_pixel),
    .src_width  (src_width_r),
    .src_height (src_height_r),
    .q_count    (q_count),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // Work queue
  bu2x_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head),
    .count      (q_count)
  );

  // Back: interpolation and result beats
  bu2x_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_entry (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pixel  (out_pixel),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_last   (out_last)
  );

endmodule
